### hdl/sau_pkg.sv
// ----------------------------------------------------------------------------
// Snow albedo update package
// Shared constants, register indexes and the exp(-x) interpolation table.
// ----------------------------------------------------------------------------
`default_nettype none

package sau_pkg;

   localparam int EXP_SEGMENTS = 256;
   localparam int EXP_IW       = $clog2(EXP_SEGMENTS + 1);
   localparam int MELT_XW      = 20;
   localparam int EXP_PW       = MELT_XW + EXP_IW;
   localparam int EXP_VW       = 31;

   localparam int DIV_NW = 48;
   localparam int DIV_DW = 24;
   localparam int DIV_QW = 23;

   localparam logic [16:0] ONE_Q15  = 17'd32768;
   localparam logic [16:0] REFRESH_FULL = 17'd65536;
   localparam logic [23:0] RATE_MAX = 24'h7FFFFF;
   localparam logic [23:0] RATE_MIN = 24'h800000;

   localparam logic [2:0] CSR_MAX_ALBEDO  = 3'd0;
   localparam logic [2:0] CSR_MIN_ALBEDO  = 3'd1;
   localparam logic [2:0] CSR_BASE_ALBEDO = 3'd2;
   localparam logic [2:0] CSR_DECAY       = 3'd3;
   localparam logic [2:0] CSR_MELT_SCALE  = 3'd4;
   localparam logic [2:0] CSR_FRESH_DEPTH = 3'd5;
   localparam logic [2:0] CSR_STEP_LENGTH = 3'd6;
   localparam logic [2:0] CSR_SPARE       = 3'd7;

   typedef logic [EXP_VW-1:0] exp_tab_type [0:EXP_SEGMENTS];

   // Shift and subtract quotient, used only while the table is built.
   function automatic longint unsigned const_div(input longint unsigned n,
         input longint unsigned d);
      longint unsigned q;
      longint unsigned r;
      q = 0;
      r = 0;
      for (int b = 63; b >= 0; b--) begin
         r = {r[62:0], n[b]};
         q = q << 1;
         if (r >= d) begin
            r = r - d;
            q = q | 64'd1;
         end
      end
      return q;
   endfunction

   // Truncated alternating series for exp(-f / 65536), Q2.30.
   function automatic longint unsigned exp_frac(input longint unsigned f);
      longint sum;
      longint unsigned term;
      sum  = 64'sd1073741824;
      term = 64'd1073741824;
      for (longint unsigned kk = 1; kk <= 14; kk++) begin
         term = const_div(term * f, 64'd65536 * kk);
         if (kk[0]) begin
            sum = sum - longint'(term);
         end else begin
            sum = sum + longint'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      return unsigned'(sum);
   endfunction

   function automatic longint unsigned exp_neg_q16(input longint unsigned t);
      longint unsigned v;
      longint unsigned e1;
      longint unsigned n;
      v  = exp_frac(t & 64'hFFFF);
      e1 = exp_frac(64'd65536);
      n  = t >> 16;
      for (longint unsigned j = 0; j < 16; j++) begin
         if (j < n) begin
            v = (v * e1) >> 30;
         end
      end
      return v;
   endfunction

   function automatic exp_tab_type exp_table();
      exp_tab_type tab;
      for (int k = 0; k <= EXP_SEGMENTS; k++) begin
         tab[k] = EXP_VW'(exp_neg_q16((longint'(k) * 64'd1048576) / EXP_SEGMENTS));
      end
      return tab;
   endfunction

   localparam exp_tab_type EXP_TAB = exp_table();

endpackage

`default_nettype wire

### hdl/sau_div.sv
// ----------------------------------------------------------------------------
// Pipelined restoring divider
// Produces one quotient bit per stage; the quotient must fit in DIV_QW bits.
// ----------------------------------------------------------------------------
`default_nettype none

module sau_div
   import sau_pkg::*;
(
   input  wire logic              clock,
   input  wire logic [DIV_NW-1:0] num,
   input  wire logic [DIV_DW-1:0] den,
   output      logic [DIV_QW-1:0] quo
);

   logic [DIV_NW-1:0] rem_ff [DIV_QW];
   logic [DIV_NW-1:0] rem_in [DIV_QW];
   logic [DIV_DW-1:0] den_ff [DIV_QW];
   logic [DIV_DW-1:0] den_in [DIV_QW];
   logic [DIV_QW-1:0] quo_ff [DIV_QW];
   logic [DIV_QW-1:0] quo_in [DIV_QW];

   for (genvar k = 0; k < DIV_QW; k++) begin : g_stage
      logic [DIV_NW-1:0] r_src;
      logic [DIV_DW-1:0] d_src;
      logic [DIV_QW-1:0] q_src;
      logic [DIV_NW-1:0] shd;

      if (k == 0) begin : g_first
         assign r_src = num;
         assign d_src = den;
         assign q_src = '0;
      end else begin : g_next
         assign r_src = rem_ff[k-1];
         assign d_src = den_ff[k-1];
         assign q_src = quo_ff[k-1];
      end

      assign shd = DIV_NW'(d_src) << (DIV_QW - 1 - k);

      always_comb begin
         den_in[k] = d_src;
         if (r_src >= shd) begin
            rem_in[k] = r_src - shd;
            quo_in[k] = q_src | (DIV_QW'(1) << (DIV_QW - 1 - k));
         end else begin
            rem_in[k] = r_src;
            quo_in[k] = q_src;
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_QW; k++) begin
         rem_ff[k] <= rem_in[k];
         den_ff[k] <= den_in[k];
         quo_ff[k] <= quo_in[k];
      end
   end

   assign quo = quo_ff[DIV_QW-1];

endmodule

`default_nettype wire

### hdl/snow_albedo_update.sv
// ----------------------------------------------------------------------------
// Snow albedo update
// Streaming albedo evolution for one land unit per transaction.
// ----------------------------------------------------------------------------
// A transaction is accepted at a rising edge with start high and busy low.
// Fields arrive on the req_ ports; one result per transaction leaves on the
// rsp_ ports, marked by rsp_valid for exactly one cycle once the transaction has
// left the pipeline. Results leave in the order transactions were accepted.
// Throughput is one transaction per cycle: busy is low except in the cycle after
// reset. The pipeline holds three 23-stage pipelined dividers, for the melt
// exponent, the snowfall refresh share and the rate, the first two running side
// by side and the rate divider following them. The csr_ port writes the seven
// configuration registers; writes take effect at once, and the user must make
// them only while no transaction is in flight; the block does not enforce this.
// Reset clears the pipeline valid bits and loads the register defaults.
// The receiver cannot hold results off; every result is presented once.
// ----------------------------------------------------------------------------
`default_nettype none

module snow_albedo_update
   import sau_pkg::*;
(
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic        req_is_lake,
   input  wire logic [23:0] req_snow_amount,
   input  wire logic [15:0] req_albedo_in,
   input  wire logic [23:0] req_melt_total,
   input  wire logic [23:0] req_precip_rate,
   input  wire logic [15:0] req_snow_share,
   output      logic        rsp_valid,
   output      logic [15:0] rsp_albedo_out,
   output      logic signed [23:0] rsp_albedo_rate,
   input  wire logic        csr_we,
   input  wire logic [2:0]  csr_index,
   input  wire logic [23:0] csr_wdata
);

   localparam int ST_MQ   = 1 + DIV_QW;
   localparam int ST_SQ   = 4 + DIV_QW;
   localparam int ST_SEL  = ST_MQ + 6;
   localparam int ST_FIN  = ST_MQ + 8;
   localparam int ST_LAST = ST_FIN + DIV_QW;

   typedef struct packed {
      logic        v;
      logic        lake;
      logic        snow_nz;
      logic [15:0] old;
      logic [15:0] acap;
      logic        ovf;
      logic        gt;
      logic        lt;
      logic [16:0] adec;
      logic        snowy;
      logic        sf_nz;
      logic        sfsat;
      logic [16:0] sfs;
      logic [15:0] af;
      logic        neg;
      logic        rsat;
   } carry_type;

   carry_type c_ff [1:ST_LAST];
   carry_type c_in [1:ST_LAST];

   logic [15:0] max_albedo_ff, min_albedo_ff, base_albedo_ff, decay_ff;
   logic [23:0] melt_scale_ff, fresh_depth_ff;
   logic [20:0] step_length_ff;
   logic        busy_ff;

   logic [23:0] melt_ff, precip_ff;
   logic [15:0] share_ff;
   logic [39:0] sfprod_ff, sfprod_in;
   logic [24:0] sf_ff;
   logic [45:0] sdt_ff, sdt_in;
   logic [EXP_PW-1:0] p_ff, p_in;
   logic [EXP_VW-1:0] lo_ff, lo_in, hi_ff, hi_in, lo2_ff, e_ff, e_in;
   logic [MELT_XW-1:0] r_ff;
   logic [EXP_IW-1:0] idx;
   logic        down_ff, down_in;
   logic [EXP_VW-1:0] diff;
   logic [50:0] dprod_ff, dprod_in;
   logic [46:0] aprod;
   logic [15:0] aexp_ff;
   logic [16:0] asel_ff, asel_in, a31_ff, dm, a2;
   logic        up_ff, up_in;
   logic [33:0] rprod_ff, rprod_in;
   logic [16:0] af_wide;
   logic [15:0] rdiff;
   logic        rneg;
   logic        rsp_valid_ff;
   logic [15:0] rsp_albedo_ff;
   logic [23:0] rsp_rate_ff, rate_in;
   logic [31:0] dprod16;

   logic [23:0] ms_eff, fd_eff;
   logic [20:0] dt_eff;
   logic [DIV_NW-1:0] mnum, snum, rnum;
   logic [DIV_QW-1:0] mquo, squo, rquo;

   assign ms_eff = (melt_scale_ff == '0) ? 24'd1 : melt_scale_ff;
   assign fd_eff = (fresh_depth_ff == '0) ? 24'd1 : fresh_depth_ff;
   assign dt_eff = (step_length_ff == '0) ? 21'd1 : step_length_ff;

   assign mnum  = {8'd0, melt_ff, 16'd0};
   assign snum  = {2'd0, sdt_ff};
   assign rdiff = rneg ? (c_ff[ST_FIN].old - c_ff[ST_FIN].af)
                       : (c_ff[ST_FIN].af - c_ff[ST_FIN].old);
   assign rneg  = c_ff[ST_FIN].af < c_ff[ST_FIN].old;
   assign rnum  = {15'd0, rdiff, 17'd0};

   sau_div u_melt_div (.clock(clock), .num(mnum), .den(ms_eff), .quo(mquo));
   sau_div u_snow_div (.clock(clock), .num(snum), .den(fd_eff), .quo(squo));
   sau_div u_rate_div (.clock(clock), .num(rnum), .den(DIV_DW'(dt_eff)), .quo(rquo));

   always_ff @(posedge clock) begin
      if (reset) begin
         max_albedo_ff  <= 16'd29491;
         min_albedo_ff  <= 16'd9830;
         base_albedo_ff <= 16'd21299;
         decay_ff       <= 16'd29491;
         melt_scale_ff  <= 24'd384000;
         fresh_depth_ff <= 24'd3840;
         step_length_ff <= 21'd65536;
      end else if (csr_we) begin
         case (csr_index)
            CSR_MAX_ALBEDO:  max_albedo_ff  <= csr_wdata[15:0];
            CSR_MIN_ALBEDO:  min_albedo_ff  <= csr_wdata[15:0];
            CSR_BASE_ALBEDO: base_albedo_ff <= csr_wdata[15:0];
            CSR_DECAY:       decay_ff       <= csr_wdata[15:0];
            CSR_MELT_SCALE:  melt_scale_ff  <= csr_wdata;
            CSR_FRESH_DEPTH: fresh_depth_ff <= csr_wdata;
            CSR_STEP_LENGTH: step_length_ff <= csr_wdata[20:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      idx      = p_ff[EXP_PW-1:MELT_XW];
      lo_in    = EXP_TAB[idx];
      hi_in    = EXP_TAB[EXP_IW'(idx + 1'b1)];
      down_in  = lo_ff >= hi_ff;
      diff     = down_in ? (lo_ff - hi_ff) : (hi_ff - lo_ff);
      dprod_in = 51'(diff) * 51'(r_ff);
      if (c_ff[ST_MQ+3].ovf) begin
         e_in = '0;
      end else if (down_ff) begin
         e_in = lo2_ff - dprod_ff[50:20];
      end else begin
         e_in = lo2_ff + dprod_ff[50:20];
      end
      aprod = 47'(base_albedo_ff) * 47'(e_ff);

      sfprod_in = 40'(precip_ff) * 40'(share_ff);
      sdt_in    = 46'(sf_ff) * 46'(dt_eff);
      p_in      = EXP_PW'(mquo[MELT_XW-1:0]) * EXP_PW'(EXP_SEGMENTS);

      if (c_ff[ST_SEL-1].gt) begin
         asel_in = c_ff[ST_SEL-1].adec;
      end else if (c_ff[ST_SEL-1].lt) begin
         asel_in = {1'b0, aexp_ff};
      end else begin
         asel_in = {1'b0, c_ff[ST_SEL-1].acap};
      end
      if (asel_in < {1'b0, min_albedo_ff}) begin
         asel_in = {1'b0, min_albedo_ff};
      end

      up_in    = {1'b0, max_albedo_ff} >= asel_ff;
      dm       = up_in ? ({1'b0, max_albedo_ff} - asel_ff) : (asel_ff - {1'b0, max_albedo_ff});
      rprod_in = 34'(c_ff[ST_SEL].sfs) * 34'(dm);

      if (!c_ff[ST_FIN-1].sf_nz) begin
         a2 = a31_ff;
      end else if (up_ff) begin
         a2 = a31_ff + rprod_ff[32:16];
      end else begin
         a2 = a31_ff - rprod_ff[32:16];
      end
      af_wide = (c_ff[ST_FIN-1].snowy && !c_ff[ST_FIN-1].lake) ? a2
                                                               : {1'b0, c_ff[ST_FIN-1].old};
      if (af_wide > ONE_Q15) begin
         af_wide = ONE_Q15;
      end

      dprod16 = 32'(c_ff[2].acap) * 32'(decay_ff);

      c_in[1]         = '0;
      c_in[1].v       = start && !busy_ff;
      c_in[1].lake    = req_is_lake;
      c_in[1].snow_nz = req_snow_amount != '0;
      c_in[1].old     = req_albedo_in;
      for (int n = 2; n <= ST_LAST; n++) begin
         c_in[n] = c_ff[n-1];
      end
      c_in[2].acap  = (c_ff[1].old > max_albedo_ff) ? max_albedo_ff : c_ff[1].old;
      c_in[2].ovf   = 28'(melt_ff) >= {ms_eff, 4'd0};
      c_in[3].gt    = c_ff[2].acap > base_albedo_ff;
      c_in[3].lt    = c_ff[2].acap < base_albedo_ff;
      c_in[3].adec  = dprod16[31:15];
      c_in[3].sf_nz = sfprod_ff[39:15] != '0;
      c_in[3].snowy = c_ff[2].snow_nz || (sfprod_ff[39:15] != '0);
      c_in[5].sfsat = sdt_ff >= {6'd0, fd_eff, 16'd0};
      c_in[ST_SQ+1].sfs = c_ff[ST_SQ].sfsat ? REFRESH_FULL : {1'b0, squo[15:0]};
      c_in[ST_FIN].af   = af_wide[15:0];
      c_in[ST_FIN+1].neg  = rneg;
      c_in[ST_FIN+1].rsat = 27'(rdiff) >= {dt_eff, 6'd0};

      if (c_ff[ST_LAST].lake) begin
         rate_in = '0;
      end else if (c_ff[ST_LAST].rsat) begin
         rate_in = c_ff[ST_LAST].neg ? RATE_MIN : RATE_MAX;
      end else if (c_ff[ST_LAST].neg) begin
         rate_in = 24'(0) - {1'b0, rquo};
      end else begin
         rate_in = {1'b0, rquo};
      end
   end

   always_ff @(posedge clock) begin
      melt_ff   <= req_melt_total;
      precip_ff <= req_precip_rate;
      share_ff  <= req_snow_share;
      sfprod_ff <= sfprod_in;
      sf_ff     <= sfprod_ff[39:15];
      sdt_ff    <= sdt_in;
      p_ff      <= p_in;
      lo_ff     <= lo_in;
      hi_ff     <= hi_in;
      r_ff      <= p_ff[MELT_XW-1:0];
      down_ff   <= down_in;
      lo2_ff    <= lo_ff;
      dprod_ff  <= dprod_in;
      e_ff      <= e_in;
      aexp_ff   <= aprod[45:30];
      asel_ff   <= asel_in;
      a31_ff    <= asel_ff;
      up_ff     <= up_in;
      rprod_ff  <= rprod_in;
      rsp_albedo_ff <= c_ff[ST_LAST].af;
      rsp_rate_ff   <= rate_in;
      if (reset) begin
         for (int n = 1; n <= ST_LAST; n++) begin
            c_ff[n] <= '0;
         end
         rsp_valid_ff <= 1'b0;
         busy_ff      <= 1'b1;
      end else begin
         for (int n = 1; n <= ST_LAST; n++) begin
            c_ff[n] <= c_in[n];
         end
         rsp_valid_ff <= c_ff[ST_LAST].v;
         busy_ff      <= 1'b0;
      end
   end

   assign busy            = busy_ff;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_albedo_out  = rsp_albedo_ff;
   assign rsp_albedo_rate = rsp_rate_ff;

   a_out_follows_pipe: assert property (@(posedge clock) disable iff (reset)
      c_ff[ST_LAST].v |=> rsp_valid)
      else $error("Result strobe missing for a completed transaction.");

   a_albedo_clamped: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> {1'b0, rsp_albedo_out} <= ONE_Q15)
      else $error("Albedo result exceeds one.");

   a_lake_rate_zero: assert property (@(posedge clock) disable iff (reset)
      c_ff[ST_LAST].v && c_ff[ST_LAST].lake |=> rsp_albedo_rate == '0)
      else $error("Lake transaction reported a nonzero rate.");

   a_no_snow_passes: assert property (@(posedge clock) disable iff (reset)
      c_ff[ST_FIN].v && !c_ff[ST_FIN].snowy && {1'b0, c_ff[ST_FIN].old} <= ONE_Q15
      |-> c_ff[ST_FIN].af == c_ff[ST_FIN].old)
      else $error("Albedo changed without snow.");

endmodule

`default_nettype wire
